>>> rtl/core/expression_token_lexer_assert.svh
// Assertion macros shared by the lexer's checker.
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ETL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("expression_token_lexer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ETL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("expression_token_lexer: next-cycle check failed");

// The consequent must hold in the cycle after reset is seen.
`define ETL_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("expression_token_lexer: post-reset check failed");

`endif

>>> rtl/core/etl_pkg.sv
`timescale 1ns / 1ps
package etl_pkg;

   localparam int POSITION_BITS     = 16;
   localparam int VALUE_BITS        = 32;
   localparam int CHAR_BITS         = 8;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int KW_LEN_BITS       = 4;
   localparam int DEF_KEYWORD_CHARS = 8;
   localparam int DEF_QUEUE_DEPTH   = 4;

   localparam logic [CHAR_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_STAR    = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CHAR_OPEN    = 8'h28;
   localparam logic [CHAR_BITS-1:0] CHAR_CLOSE   = 8'h29;
   localparam logic [CHAR_BITS-1:0] CHAR_AMP     = 8'h26;
   localparam logic [CHAR_BITS-1:0] CHAR_PIPE    = 8'h7C;
   localparam logic [CHAR_BITS-1:0] CHAR_EQ      = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CHAR_BANG    = 8'h21;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KW1_CHARS  = 2'd0,
      CSR_KW1_LENGTH = 2'd1,
      CSR_KW2_CHARS  = 2'd2,
      CSR_KW2_LENGTH = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      KIND_EOF    = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_SPACE  = 4'd2,
      KIND_WORD   = 4'd3,
      KIND_PLUS   = 4'd4,
      KIND_MINUS  = 4'd5,
      KIND_STAR   = 4'd6,
      KIND_SLASH  = 4'd7,
      KIND_OPEN   = 4'd8,
      KIND_CLOSE  = 4'd9,
      KIND_ANDAND = 4'd10,
      KIND_OROR   = 4'd11,
      KIND_EQEQ   = 4'd12,
      KIND_NOTEQ  = 4'd13,
      KIND_BANG   = 4'd14,
      KIND_ERROR  = 4'd15
   } kind_type;

   typedef enum logic [3:0] {
      CH_DIGIT, CH_SPACE, CH_LETTER, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
      CH_OPEN, CH_CLOSE, CH_AMP, CH_PIPE, CH_EQ, CH_BANG, CH_OTHER, CH_END
   } chr_type;

   typedef enum logic [1:0] {
      RUN_NONE   = 2'd0,
      RUN_NUMBER = 2'd1,
      RUN_SPACE  = 2'd2,
      RUN_WORD   = 2'd3
   } run_type;

   typedef enum logic [2:0] {
      PEND_NONE = 3'd0,
      PEND_AMP  = 3'd1,
      PEND_PIPE = 3'd2,
      PEND_EQ   = 3'd3,
      PEND_BANG = 3'd4
   } pend_type;

   typedef enum logic [1:0] {
      KW_NONE = 2'd0,
      KW_ONE  = 2'd1,
      KW_TWO  = 2'd2
   } kw_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'b01,
      PH_SECOND = 2'b10
   } phase_type;

   typedef struct packed {
      chr_type              code;
      logic [CHAR_BITS-1:0] chr;
   } item_type;

   typedef struct packed {
      kind_type                 kind;
      logic [POSITION_BITS-1:0] start;
      logic [POSITION_BITS-1:0] length;
      logic [VALUE_BITS-1:0]    value;
      logic                     overflow;
      kw_type                   kw;
   } tok_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] one_chars;
      logic [KW_LEN_BITS-1:0]   one_len;
      logic [CSR_DATA_BITS-1:0] two_chars;
      logic [KW_LEN_BITS-1:0]   two_len;
   } kw_cfg_type;

   // Maps one text byte onto the class the back end works with.
   function automatic chr_type classify(input logic [CHAR_BITS-1:0] c);
      chr_type code;
      case (c)
         CHAR_SPACE: code = CH_SPACE;
         CHAR_PLUS:  code = CH_PLUS;
         CHAR_MINUS: code = CH_MINUS;
         CHAR_STAR:  code = CH_STAR;
         CHAR_SLASH: code = CH_SLASH;
         CHAR_OPEN:  code = CH_OPEN;
         CHAR_CLOSE: code = CH_CLOSE;
         CHAR_AMP:   code = CH_AMP;
         CHAR_PIPE:  code = CH_PIPE;
         CHAR_EQ:    code = CH_EQ;
         CHAR_BANG:  code = CH_BANG;
         default: begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               code = CH_DIGIT;
            end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z],
                                   [CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
               code = CH_LETTER;
            end else begin
               code = CH_OTHER;
            end
         end
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/etl_if.sv
`timescale 1ns / 1ps
interface etl_req_if;
   import etl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] character;
   logic                 end_marker;

   modport source (output valid, output character, output end_marker, input ready);
   modport sink (input valid, input character, input end_marker, output ready);
endinterface

interface etl_rsp_if;
   import etl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [3:0]               token_kind;
   logic [POSITION_BITS-1:0] token_start;
   logic [POSITION_BITS-1:0] token_length;
   logic [VALUE_BITS-1:0]    number_value;
   logic                     number_overflow;
   logic [1:0]               keyword_match;
   logic                     last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output number_value, output number_overflow,
                   output keyword_match, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_length,
                 input number_value, input number_overflow, input keyword_match,
                 input last_of_run, output ready);
endinterface

>>> rtl/core/expression_token_lexer.sv
// A beat is classified as it is accepted and written into the queue; the back end takes
// it from the queue head and loads the first token it causes into the result register,
// which drives rsp_chan directly. One character beat is taken per cycle while the queue
// has room; the single result register lets out one token a cycle while the receiver is
// ready, so an item that causes two tokens holds the back end until its second is loaded.
// Reset (synchronous, active high) empties the queue and the result register, closes any
// run, clears the text position and sets both keywords to zero length.
`timescale 1ns / 1ps
module expression_token_lexer #(
   parameter int KEYWORD_CHARS = etl_pkg::DEF_KEYWORD_CHARS,
   parameter int QUEUE_DEPTH   = etl_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   etl_req_if.sink                              req_chan,
   etl_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [etl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [etl_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import etl_pkg::*;

   // The front end classifies each character beat and pushes it into a short queue.
   // The back end drains that queue, keeps the open run (number, spaces or word) and
   // a held first character of a two-character operator, and turns each item into
   // zero, one or two tokens. The queue lets the input keep streaming while the back
   // end sends out both tokens of an item that closes one token and emits another.

   kw_cfg_type kw_cfg_ff, kw_cfg_in;

   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   item_type q_head;
   logic     q_empty;
   logic     q_full;

   logic     rsp_valid;
   tok_type  rsp_tok;
   logic     rsp_last;

   // Keyword registers. The user must write them only while the block is idle (the block
   // does not enforce it), so the back end can compare against them directly.
   always_comb begin
      kw_cfg_in = kw_cfg_ff;
      if (csr_write_enable) begin
         case (csr_type'(csr_index))
            CSR_KW1_CHARS:  kw_cfg_in.one_chars = csr_data;
            CSR_KW1_LENGTH: kw_cfg_in.one_len   = csr_data[KW_LEN_BITS-1:0];
            CSR_KW2_CHARS:  kw_cfg_in.two_chars = csr_data;
            CSR_KW2_LENGTH: kw_cfg_in.two_len   = csr_data[KW_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_cfg_ff <= '0;
      end else begin
         kw_cfg_ff <= kw_cfg_in;
      end
   end

   etl_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_push_item)
   );

   etl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   etl_back #(
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .kw_cfg    (kw_cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_tok   (rsp_tok),
      .rsp_last  (rsp_last)
   );

   // The result register in the back end drives the result beat directly.
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.token_kind      = rsp_tok.kind;
   assign rsp_chan.token_start     = rsp_tok.start;
   assign rsp_chan.token_length    = rsp_tok.length;
   assign rsp_chan.number_value    = rsp_tok.value;
   assign rsp_chan.number_overflow = rsp_tok.overflow;
   assign rsp_chan.keyword_match   = rsp_tok.kw;
   assign rsp_chan.last_of_run     = rsp_last;

endmodule

>>> rtl/core/etl_front.sv
`timescale 1ns / 1ps
module etl_front (
   etl_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             q_push,
   output etl_pkg::item_type q_item
);
   import etl_pkg::*;

   // A beat is taken whenever the queue has room.
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      q_item.chr  = req_chan.character;
      q_item.code = req_chan.end_marker ? CH_END : classify(req_chan.character);
   end

endmodule

>>> rtl/core/etl_queue.sv
`timescale 1ns / 1ps
module etl_queue #(
   parameter int DEPTH = etl_pkg::DEF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  etl_pkg::item_type push_item,
   input  logic              pop,
   output etl_pkg::item_type head,
   output logic              empty,
   output logic              full
);
   import etl_pkg::*;

   // DEPTH must be a power of two of at least two (not checked here), so the pointers wrap by themselves.
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_ok;
   logic                pop_ok;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push_ok) - CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/etl_back.sv
`timescale 1ns / 1ps
module etl_back #(
   parameter int KEYWORD_CHARS = etl_pkg::DEF_KEYWORD_CHARS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  etl_pkg::item_type   q_head,
   output logic                q_pop,
   input  etl_pkg::kw_cfg_type kw_cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output etl_pkg::tok_type    rsp_tok,
   output logic                rsp_last
);
   import etl_pkg::*;

   localparam int WORD_BITS  = CHAR_BITS * KEYWORD_CHARS;
   localparam int WIDE_BITS  = VALUE_BITS + 4;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [WIDE_BITS-1:0] VALUE_MAX_WIDE = {4'b0000, {VALUE_BITS{1'b1}}};

   // Run and operator state.
   run_type                  run_class_ff, run_class_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;
   logic [POSITION_BITS-1:0] run_length_ff, run_length_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic [WORD_BITS-1:0]     word_ff, word_in;
   pend_type                 pend_ff, pend_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   phase_type                phase_ff, phase_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   tok_type                  tok_ff;
   logic                     last_ff;

   logic                     is_end;
   run_type                  cls;
   logic [POSITION_BITS-1:0] pos_prev;
   logic                     pair_hit;
   kind_type                 pair_kind;
   logic                     extend;
   logic                     start_run;
   pend_type                 new_pend;
   logic                     a_v, b_v, c_v;
   tok_type                  a_tok, b_tok, c_tok;
   tok_type                  t0, t1;
   logic                     any_tok, two_tok;
   logic                     out_free, load, commit;
   logic                     hit_one, hit_two;

   logic [POSITION_BITS-1:0] base_len;
   logic [VALUE_BITS-1:0]    base_acc;
   logic                     base_ovf;
   logic [WORD_BITS-1:0]     base_word;
   logic [WIDE_BITS-1:0]     acc_wide;
   logic [WIDE_BITS-1:0]     acc_x10;
   run_type                  grow_class;

   function automatic logic kw_hit(input logic [WORD_BITS-1:0]     word,
                                   input logic [POSITION_BITS-1:0] run_len,
                                   input logic [CSR_DATA_BITS-1:0] chars,
                                   input logic [KW_LEN_BITS-1:0]   len);
      logic match;
      match = (len != '0) && (len <= KW_LEN_BITS'(KEYWORD_CHARS))
              && (POSITION_BITS'(len) == run_len);
      for (int b = 0; b < KEYWORD_CHARS; b++) begin
         if ((KW_LEN_BITS'(b) < len)
             && (word[b*CHAR_BITS +: CHAR_BITS] != chars[b*CHAR_BITS +: CHAR_BITS])) begin
            match = 1'b0;
         end
      end
      return match;
   endfunction

   assign is_end   = (q_head.code == CH_END);
   assign pos_prev = pos_ff - POSITION_BITS'(1);

   always_comb begin
      case (q_head.code)
         CH_DIGIT:  cls = RUN_NUMBER;
         CH_SPACE:  cls = RUN_SPACE;
         CH_LETTER: cls = RUN_WORD;
         default:   cls = RUN_NONE;
      endcase
   end

   // Held operator: either it pairs with this byte or it is flushed on its own.
   always_comb begin
      pair_hit  = 1'b0;
      pair_kind = KIND_ERROR;
      case (pend_ff)
         PEND_AMP: begin
            pair_hit  = (q_head.code == CH_AMP);
            pair_kind = KIND_ANDAND;
         end
         PEND_PIPE: begin
            pair_hit  = (q_head.code == CH_PIPE);
            pair_kind = KIND_OROR;
         end
         PEND_EQ: begin
            pair_hit  = (q_head.code == CH_EQ);
            pair_kind = KIND_EQEQ;
         end
         PEND_BANG: begin
            pair_hit  = (q_head.code == CH_EQ);
            pair_kind = KIND_NOTEQ;
         end
         default: ;
      endcase
      if (is_end) begin
         pair_hit = 1'b0;
      end

      a_v         = (pend_ff != PEND_NONE);
      a_tok       = '0;
      a_tok.start = pos_prev;
      if (pair_hit) begin
         a_tok.kind   = pair_kind;
         a_tok.length = POSITION_BITS'(2);
      end else begin
         a_tok.kind   = (pend_ff == PEND_BANG) ? KIND_BANG : KIND_ERROR;
         a_tok.length = POSITION_BITS'(1);
      end
   end

   // Open run: closed by end of text or by a byte of another class.
   always_comb begin
      hit_one = kw_hit(word_ff, run_length_ff, kw_cfg.one_chars, kw_cfg.one_len);
      hit_two = kw_hit(word_ff, run_length_ff, kw_cfg.two_chars, kw_cfg.two_len);

      b_tok        = '0;
      b_tok.start  = run_start_ff;
      b_tok.length = run_length_ff;
      case (run_class_ff)
         RUN_NUMBER: begin
            b_tok.kind     = KIND_NUMBER;
            b_tok.value    = acc_ff;
            b_tok.overflow = ovf_ff;
         end
         RUN_SPACE: b_tok.kind = KIND_SPACE;
         RUN_WORD: begin
            b_tok.kind = KIND_WORD;
            b_tok.kw   = hit_one ? KW_ONE : (hit_two ? KW_TWO : KW_NONE);
         end
         default: ;
      endcase

      extend    = !is_end && !pair_hit && (run_class_ff != RUN_NONE)
                  && (cls == run_class_ff);
      b_v       = (run_class_ff != RUN_NONE) && (is_end || (!pair_hit && !extend));
      start_run = !is_end && !pair_hit && !extend && (cls != RUN_NONE);
   end

   // The byte itself: a one-character operator, an unknown character, a held operator or end of text.
   always_comb begin
      c_v          = 1'b0;
      new_pend     = PEND_NONE;
      c_tok        = '0;
      c_tok.start  = pos_ff;
      c_tok.length = POSITION_BITS'(1);
      if (is_end) begin
         c_v          = 1'b1;
         c_tok.kind   = KIND_EOF;
         c_tok.length = '0;
      end else if (!pair_hit && !extend && (cls == RUN_NONE)) begin
         c_v = 1'b1;
         case (q_head.code)
            CH_PLUS:  c_tok.kind = KIND_PLUS;
            CH_MINUS: c_tok.kind = KIND_MINUS;
            CH_STAR:  c_tok.kind = KIND_STAR;
            CH_SLASH: c_tok.kind = KIND_SLASH;
            CH_OPEN:  c_tok.kind = KIND_OPEN;
            CH_CLOSE: c_tok.kind = KIND_CLOSE;
            CH_AMP: begin
               c_v      = 1'b0;
               new_pend = PEND_AMP;
            end
            CH_PIPE: begin
               c_v      = 1'b0;
               new_pend = PEND_PIPE;
            end
            CH_EQ: begin
               c_v      = 1'b0;
               new_pend = PEND_EQ;
            end
            CH_BANG: begin
               c_v      = 1'b0;
               new_pend = PEND_BANG;
            end
            default: c_tok.kind = KIND_ERROR;
         endcase
      end
   end

   // Growing a run by one byte; a fresh run starts from empty values.
   always_comb begin
      base_len   = start_run ? '0 : run_length_ff;
      base_acc   = start_run ? '0 : acc_ff;
      base_ovf   = start_run ? 1'b0 : ovf_ff;
      base_word  = start_run ? '0 : word_ff;
      grow_class = start_run ? cls : run_class_ff;
      acc_wide   = WIDE_BITS'(base_acc);
      acc_x10    = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(q_head.chr[3:0]);
   end

   always_comb begin
      run_class_in  = run_class_ff;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      word_in       = word_ff;
      pend_in       = new_pend;
      pos_in        = pos_ff + POSITION_BITS'(1);
      if (is_end) begin
         run_class_in  = RUN_NONE;
         run_start_in  = '0;
         run_length_in = '0;
         acc_in        = '0;
         ovf_in        = 1'b0;
         word_in       = '0;
         pend_in       = PEND_NONE;
         pos_in        = '0;
      end else begin
         if (b_v) begin
            run_class_in  = RUN_NONE;
            run_length_in = '0;
            acc_in        = '0;
            ovf_in        = 1'b0;
            word_in       = '0;
         end
         if (extend || start_run) begin
            run_class_in  = grow_class;
            run_start_in  = start_run ? pos_ff : run_start_ff;
            run_length_in = (base_len == POS_MAX) ? base_len : base_len + POSITION_BITS'(1);
            acc_in        = base_acc;
            ovf_in        = base_ovf;
            word_in       = base_word;
            if (grow_class == RUN_NUMBER) begin
               if (acc_x10 > VALUE_MAX_WIDE) begin
                  acc_in = '1;
                  ovf_in = 1'b1;
               end else begin
                  acc_in = acc_x10[VALUE_BITS-1:0];
               end
            end
            if (grow_class == RUN_WORD) begin
               for (int b = 0; b < KEYWORD_CHARS; b++) begin
                  if (base_len == POSITION_BITS'(b)) begin
                     word_in[b*CHAR_BITS +: CHAR_BITS] = q_head.chr;
                  end
               end
            end
         end
      end
   end

   // Up to two tokens per item leave one a cycle while the result register is free; state moves on with the last one.
   always_comb begin
      t0       = a_v ? a_tok : (b_v ? b_tok : c_tok);
      t1       = (a_v && b_v) ? b_tok : c_tok;
      any_tok  = a_v || b_v || c_v;
      two_tok  = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
      out_free = !rsp_valid_ff || rsp_ready;
      load     = !q_empty && any_tok && out_free;
      commit   = !q_empty && (!any_tok
                 || (out_free && (!two_tok || (phase_ff == PH_SECOND))));

      phase_in = phase_ff;
      if (load && two_tok && (phase_ff == PH_FIRST)) begin
         phase_in = PH_SECOND;
      end else if (commit) begin
         phase_in = PH_FIRST;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign q_pop     = commit;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tok   = tok_ff;
   assign rsp_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff  <= RUN_NONE;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         word_ff       <= '0;
         pend_ff       <= PEND_NONE;
         pos_ff        <= '0;
         phase_ff      <= PH_FIRST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (commit) begin
            run_class_ff  <= run_class_in;
            run_start_ff  <= run_start_in;
            run_length_ff <= run_length_in;
            acc_ff        <= acc_in;
            ovf_ff        <= ovf_in;
            word_ff       <= word_in;
            pend_ff       <= pend_in;
            pos_ff        <= pos_in;
         end
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= (phase_ff == PH_SECOND) ? t1 : t0;
         last_ff <= !two_tok || (phase_ff == PH_SECOND);
      end
   end

endmodule

>>> rtl/core/etl_checker.sv
`timescale 1ns / 1ps
`include "expression_token_lexer_assert.svh"
module etl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [3:0]                        rsp_kind,
   input logic [etl_pkg::POSITION_BITS-1:0] rsp_start,
   input logic [etl_pkg::POSITION_BITS-1:0] rsp_length,
   input logic [etl_pkg::VALUE_BITS-1:0]    rsp_value,
   input logic                              rsp_overflow,
   input logic [1:0]                        rsp_kw,
   input logic                              rsp_last
);
   import etl_pkg::*;

   // A stalled result beat keeps its contents.
   `ETL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_start) && $stable(rsp_length) && $stable(rsp_value) && $stable(rsp_last))

   // Reset empties the result register.
   `ETL_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid)

   // End of text is always the last token of its item and carries no text.
   `ETL_ASSERT_NOW(a_eof_shape, clock, reset, rsp_valid && (rsp_kind == KIND_EOF), (rsp_length == '0) && rsp_last && (rsp_value == '0) && (rsp_kw == KW_NONE))

   // Number fields belong to number tokens, keyword hits to word tokens.
   `ETL_ASSERT_NOW(a_field_owner, clock, reset, rsp_valid, ((rsp_kind == KIND_NUMBER) || ((rsp_value == '0) && !rsp_overflow)) && ((rsp_kind == KIND_WORD) || (rsp_kw == KW_NONE)))

endmodule

bind expression_token_lexer etl_checker u_etl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.token_kind),
   .rsp_start    (rsp_chan.token_start),
   .rsp_length   (rsp_chan.token_length),
   .rsp_value    (rsp_chan.number_value),
   .rsp_overflow (rsp_chan.number_overflow),
   .rsp_kw       (rsp_chan.keyword_match),
   .rsp_last     (rsp_chan.last_of_run)
);

>>> test/etl_token_checker.sv
`timescale 1ns / 1ps
module etl_token_checker (
   input  logic                               clock,
   input  logic                               reset,
   etl_req_if                                 req_mon,
   etl_rsp_if                                 rsp_mon,
   input  logic                               csr_write_enable,
   input  logic [etl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [etl_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 mismatch_count,
   output int                                 tokens_outstanding
);
   import etl_pkg::*;

   localparam int KEYWORD_CHARS = DEF_KEYWORD_CHARS;
   localparam int PRINT_LIMIT   = 100;
   localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 1;

   typedef struct packed {
      kind_type                 kind;
      logic [POSITION_BITS-1:0] start;
      logic [POSITION_BITS-1:0] length;
      logic [VALUE_BITS-1:0]    value;
      logic                     overflow;
      kw_type                   kw;
      logic                     last;
   } token_beat_type;

   token_beat_type pending_tokens[$];
   token_beat_type step_tokens[$];

   kw_cfg_type               keywords;
   run_type                  lex_run;
   logic [POSITION_BITS-1:0] lex_start;
   logic [POSITION_BITS-1:0] lex_len;
   logic [VALUE_BITS-1:0]    lex_value;
   logic                     lex_ovf;
   logic [63:0]              lex_word;
   pend_type                 lex_pend;
   logic [POSITION_BITS-1:0] lex_pos;

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t ns: token mismatch on %s: got %0h, expected %0h",
                  $time, field, got, want);
      end
      mismatch_count++;
   endtask

   task automatic stage_token(input kind_type kind, input logic [POSITION_BITS-1:0] start,
                              input logic [POSITION_BITS-1:0] length,
                              input logic [VALUE_BITS-1:0] value, input logic overflow,
                              input kw_type kw);
      token_beat_type t;
      t = '{kind: kind, start: start, length: length, value: value, overflow: overflow,
            kw: kw, last: 1'b0};
      step_tokens.push_back(t);
   endtask

   function automatic logic word_matches(input logic [63:0] chars, input logic [3:0] len);
      logic [63:0] mask;
      if (len == 0 || len > KEYWORD_CHARS || lex_len != len) return 1'b0;
      mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 1);
      return ((lex_word ^ chars) & mask) == 0;
   endfunction

   function automatic run_type class_of(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return RUN_NUMBER;
      if (c == CHAR_SPACE) return RUN_SPACE;
      if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
          (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) return RUN_WORD;
      return RUN_NONE;
   endfunction

   task automatic close_run();
      kw_type kw;
      kw = KW_NONE;
      case (lex_run)
         RUN_NUMBER: stage_token(KIND_NUMBER, lex_start, lex_len, lex_value, lex_ovf, KW_NONE);
         RUN_SPACE:  stage_token(KIND_SPACE, lex_start, lex_len, '0, 1'b0, KW_NONE);
         RUN_WORD: begin
            if (word_matches(keywords.one_chars, keywords.one_len)) kw = KW_ONE;
            else if (word_matches(keywords.two_chars, keywords.two_len)) kw = KW_TWO;
            stage_token(KIND_WORD, lex_start, lex_len, '0, 1'b0, kw);
         end
         default: ;
      endcase
      lex_run   = RUN_NONE;
      lex_len   = '0;
      lex_value = '0;
      lex_ovf   = 1'b0;
      lex_word  = '0;
   endtask

   // A held first character that found no partner is reported at its own position.
   task automatic flush_pending();
      if (lex_pend == PEND_BANG) begin
         stage_token(KIND_BANG, lex_pos - POSITION_BITS'(1), 1, '0, 1'b0, KW_NONE);
      end else if (lex_pend != PEND_NONE) begin
         stage_token(KIND_ERROR, lex_pos - POSITION_BITS'(1), 1, '0, 1'b0, KW_NONE);
      end
      lex_pend = PEND_NONE;
   endtask

   task automatic extend_run(input logic [7:0] c);
      longint unsigned digit;
      digit = c - CHAR_ZERO;
      if (lex_run == RUN_NUMBER) begin
         if (lex_value > (VALUE_LIMIT - digit) / 10) begin
            lex_value = '1;
            lex_ovf   = 1'b1;
         end else begin
            lex_value = VALUE_BITS'(lex_value * 10 + digit);
         end
      end else if (lex_run == RUN_WORD && lex_len < KEYWORD_CHARS) begin
         lex_word = lex_word | ({56'd0, c} << (8 * lex_len[2:0]));
      end
      if (lex_len != {POSITION_BITS{1'b1}}) lex_len = lex_len + POSITION_BITS'(1);
   endtask

   task automatic lex_item(input logic [7:0] c, input logic ends);
      logic     done;
      kind_type pair;
      run_type  cls;
      token_beat_type t;
      step_tokens.delete();
      if (ends) begin
         close_run();
         flush_pending();
         stage_token(KIND_EOF, lex_pos, 0, '0, 1'b0, KW_NONE);
         lex_pos   = '0;
         lex_start = '0;
      end else begin
         done = 1'b0;
         if (lex_pend != PEND_NONE) begin
            pair = KIND_EOF;
            if (lex_pend == PEND_AMP && c == CHAR_AMP) pair = KIND_ANDAND;
            else if (lex_pend == PEND_PIPE && c == CHAR_PIPE) pair = KIND_OROR;
            else if (lex_pend == PEND_EQ && c == CHAR_EQ) pair = KIND_EQEQ;
            else if (lex_pend == PEND_BANG && c == CHAR_EQ) pair = KIND_NOTEQ;
            if (pair != KIND_EOF) begin
               stage_token(pair, lex_pos - POSITION_BITS'(1), 2, '0, 1'b0, KW_NONE);
               lex_pend = PEND_NONE;
               done     = 1'b1;
            end else begin
               flush_pending();
            end
         end
         cls = class_of(c);
         if (!done && lex_run != RUN_NONE) begin
            if (cls == lex_run) begin
               extend_run(c);
               done = 1'b1;
            end else begin
               close_run();
            end
         end
         if (!done) begin
            if (cls != RUN_NONE) begin
               lex_run   = cls;
               lex_start = lex_pos;
               lex_len   = '0;
               lex_value = '0;
               lex_ovf   = 1'b0;
               lex_word  = '0;
               extend_run(c);
            end else begin
               case (c)
                  CHAR_PLUS:  stage_token(KIND_PLUS, lex_pos, 1, '0, 1'b0, KW_NONE);
                  CHAR_MINUS: stage_token(KIND_MINUS, lex_pos, 1, '0, 1'b0, KW_NONE);
                  CHAR_STAR:  stage_token(KIND_STAR, lex_pos, 1, '0, 1'b0, KW_NONE);
                  CHAR_SLASH: stage_token(KIND_SLASH, lex_pos, 1, '0, 1'b0, KW_NONE);
                  CHAR_OPEN:  stage_token(KIND_OPEN, lex_pos, 1, '0, 1'b0, KW_NONE);
                  CHAR_CLOSE: stage_token(KIND_CLOSE, lex_pos, 1, '0, 1'b0, KW_NONE);
                  CHAR_AMP:   lex_pend = PEND_AMP;
                  CHAR_PIPE:  lex_pend = PEND_PIPE;
                  CHAR_EQ:    lex_pend = PEND_EQ;
                  CHAR_BANG:  lex_pend = PEND_BANG;
                  default:    stage_token(KIND_ERROR, lex_pos, 1, '0, 1'b0, KW_NONE);
               endcase
            end
         end
         lex_pos = lex_pos + POSITION_BITS'(1);
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
      while (step_tokens.size() > 0) pending_tokens.push_back(step_tokens.pop_front());
   endtask

   task automatic check_token();
      token_beat_type want;
      if (pending_tokens.size() == 0) begin
         report_mismatch("token_kind, none expected", rsp_mon.token_kind, 0);
         return;
      end
      want = pending_tokens.pop_front();
      if (rsp_mon.token_kind !== want.kind)
         report_mismatch("token_kind", rsp_mon.token_kind, want.kind);
      if (rsp_mon.token_start !== want.start)
         report_mismatch("token_start", rsp_mon.token_start, want.start);
      if (rsp_mon.token_length !== want.length)
         report_mismatch("token_length", rsp_mon.token_length, want.length);
      if (rsp_mon.number_value !== want.value)
         report_mismatch("number_value", rsp_mon.number_value, want.value);
      if (rsp_mon.number_overflow !== want.overflow)
         report_mismatch("number_overflow", rsp_mon.number_overflow, want.overflow);
      if (rsp_mon.keyword_match !== want.kw)
         report_mismatch("keyword_match", rsp_mon.keyword_match, want.kw);
      if (rsp_mon.last_of_run !== want.last)
         report_mismatch("last_of_run", rsp_mon.last_of_run, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         keywords       = '0;
         lex_run        = RUN_NONE;
         lex_start      = '0;
         lex_len        = '0;
         lex_value      = '0;
         lex_ovf        = 1'b0;
         lex_word       = '0;
         lex_pend       = PEND_NONE;
         lex_pos        = '0;
         mismatch_count = 0;
         pending_tokens.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KW1_CHARS:  keywords.one_chars = csr_data;
               CSR_KW1_LENGTH: keywords.one_len   = csr_data[KW_LEN_BITS-1:0];
               CSR_KW2_CHARS:  keywords.two_chars = csr_data;
               CSR_KW2_LENGTH: keywords.two_len   = csr_data[KW_LEN_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) lex_item(req_mon.character, req_mon.end_marker);
         if (rsp_mon.valid && rsp_mon.ready) check_token();
      end
      tokens_outstanding <= pending_tokens.size();
   end

endmodule

>>> test/tb_expression_token_lexer.sv
`timescale 1ns / 1ps
module tb_expression_token_lexer;
   import etl_pkg::*;

   // The limit leaves a wide margin above what a correct run of about 1700 beats needs,
   // even when every beat causes two tokens under the heaviest idling.
   localparam int CYCLE_LIMIT      = 200000;
   // A beat passes through the queue into the result register after acceptance, so this covers any
   // beat still in flight when the last expected token has been seen.
   localparam int DRAIN_CYCLES     = 16;
   localparam int ITEMS_PER_PHASE  = 280;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] chr;
      logic                 ends;
   } text_beat_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int mismatch_count;
   int tokens_outstanding;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // Top-side copy of the keywords, so the text generator can spell them out.
   logic [CSR_DATA_BITS-1:0] kw_chars [2];
   logic [KW_LEN_BITS-1:0]   kw_len [2];

   text_beat_type text_queue[$];

   etl_req_if req_chan ();
   etl_rsp_if rsp_chan ();

   expression_token_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   etl_token_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_chan),
      .rsp_mon            (rsp_chan),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .tokens_outstanding (tokens_outstanding)
   );

   always #4 clock = ~clock;

   // The receiver decides each cycle whether to stall; with a zero percentage it never does.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: a hung handshake or a missing token ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_expression_token_lexer: done, errors");
         $finish;
      end
   end

   function automatic logic [CHAR_BITS-1:0] random_letter();
      int r;
      r = $urandom_range(51);
      return CHAR_BITS'((r < 26) ? CHAR_UPPER_A + r : CHAR_LOWER_A + (r - 26));
   endfunction

   // Sends one beat. Every call starts and ends at a falling edge. The optional idle gap
   // comes first, so valid only drops when the sender actually decides to idle, and it
   // is never lowered and raised in the same step.
   task automatic send_item(input logic [CHAR_BITS-1:0] chr, input logic ends);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.character  <= chr;
      req_chan.end_marker <= ends;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic queue_char(input logic [CHAR_BITS-1:0] chr);
      text_queue.push_back('{chr: chr, ends: 1'b0});
   endtask

   task automatic queue_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   task automatic queue_end(input logic [CHAR_BITS-1:0] chr);
      text_queue.push_back('{chr: chr, ends: 1'b1});
   endtask

   task automatic send_text();
      text_beat_type b;
      while (text_queue.size() > 0) begin
         b = text_queue.pop_front();
         send_item(b.chr, b.ends);
      end
   endtask

   // Registers are only touched once every expected token is out and the pipeline has had
   // time to settle. Valid is dropped first so the last beat is not taken twice.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (tokens_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes all four keyword registers on back-to-back cycles. The write enable stays high
   // through the burst and drops once at the end.
   task automatic write_keywords(input logic [CSR_DATA_BITS-1:0] one_chars,
                                 input logic [KW_LEN_BITS-1:0] one_len,
                                 input logic [CSR_DATA_BITS-1:0] two_chars,
                                 input logic [KW_LEN_BITS-1:0] two_len);
      kw_chars[0] = one_chars;
      kw_len[0]   = one_len;
      kw_chars[1] = two_chars;
      kw_len[1]   = two_len;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_KW1_CHARS;
      csr_data         <= one_chars;
      @(negedge clock);
      csr_index <= CSR_KW1_LENGTH;
      csr_data  <= {{(CSR_DATA_BITS-KW_LEN_BITS){1'b0}}, one_len};
      @(negedge clock);
      csr_index <= CSR_KW2_CHARS;
      csr_data  <= two_chars;
      @(negedge clock);
      csr_index <= CSR_KW2_LENGTH;
      csr_data  <= {{(CSR_DATA_BITS-KW_LEN_BITS){1'b0}}, two_len};
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Builds one text of random pieces. Most pieces are well-formed tokens so the runs,
   // the keyword compare and the operator pairing all get exercised; lone operator
   // characters and arbitrary bytes make up the noise. Adjacent pieces can merge, which
   // gives extended runs and accidental operator pairs for free.
   task automatic queue_random_text();
      int pieces;
      int pick;
      int n;
      int slot;
      int i;
      pieces = $urandom_range(16, 1);
      repeat (pieces) begin
         pick = $urandom_range(99);
         if (pick < 18) begin
            n = $urandom_range(9);
            if (n == 0) queue_string("4294967295");
            else if (n == 1) queue_string("4294967296");
            else repeat ($urandom_range(12, 1))
               queue_char(CHAR_BITS'(CHAR_ZERO + $urandom_range(9)));
         end else if (pick < 30) begin
            repeat ($urandom_range(4, 1)) queue_char(CHAR_SPACE);
         end else if (pick < 50) begin
            slot = $urandom_range(1);
            if ($urandom_range(1) == 1 && kw_len[slot] != 0) begin
               // Spell the keyword exactly, one short, or one long. A zero byte in the
               // register ends the spelling, since it could never be part of a word.
               n = (kw_len[slot] > 8) ? 8 : kw_len[slot];
               pick = $urandom_range(3);
               if (pick == 2) n = n - 1;
               for (i = 0; i < n && kw_chars[slot][8*i +: 8] != 0; i++) begin
                  queue_char(kw_chars[slot][8*i +: 8]);
               end
               if (pick == 3) queue_char(random_letter());
            end else begin
               repeat ($urandom_range(10, 1)) queue_char(random_letter());
            end
         end else if (pick < 65) begin
            case ($urandom_range(5))
               0: queue_char(CHAR_PLUS);
               1: queue_char(CHAR_MINUS);
               2: queue_char(CHAR_STAR);
               3: queue_char(CHAR_SLASH);
               4: queue_char(CHAR_OPEN);
               default: queue_char(CHAR_CLOSE);
            endcase
         end else if (pick < 80) begin
            case ($urandom_range(3))
               0: queue_string("&&");
               1: queue_string("||");
               2: queue_string("==");
               default: queue_string("!=");
            endcase
         end else if (pick < 90) begin
            case ($urandom_range(3))
               0: queue_char(CHAR_AMP);
               1: queue_char(CHAR_PIPE);
               2: queue_char(CHAR_EQ);
               default: queue_char(CHAR_BANG);
            endcase
         end else begin
            queue_char(CHAR_BITS'($urandom_range(255)));
         end
      end
      // The byte riding on the end marker is random: the block must ignore it.
      queue_end(CHAR_BITS'($urandom_range(255)));
   endtask

   task automatic run_phase(input idle_mode_type mode,
                            input logic [CSR_DATA_BITS-1:0] one_chars,
                            input logic [KW_LEN_BITS-1:0] one_len,
                            input logic [CSR_DATA_BITS-1:0] two_chars,
                            input logic [KW_LEN_BITS-1:0] two_len);
      int sent;
      wait_idle();
      write_keywords(one_chars, one_len, two_chars, two_len);
      case (mode)
         IDLE_SENDER: begin
            sender_idle_pct    = 49;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 49;
         end
         IDLE_BOTH: begin
            sender_idle_pct    = 15;
            receiver_stall_pct = 15;
         end
         default: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         queue_random_text();
         sent += text_queue.size();
         send_text();
      end
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.character  = '0;
      req_chan.end_marker = 1'b0;
      rsp_chan.ready      = 1'b0;
      kw_chars[0] = '0;
      kw_len[0]   = '0;
      kw_chars[1] = '0;
      kw_len[1]   = '0;

      // Synchronous reset, held while the clock rises and released on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts with single-letter keywords "a" and "b". The first text covers
      // every two-character operator between plain and keyword words. The second covers
      // a bang followed by a word, a lone ampersand, pipe and equals each broken by a
      // different character, the all-ones byte as an unknown character, every single
      // operator, a space run, and a held bang flushed by the end marker.
      write_keywords(64'h61, 4'd1, 64'h62, 4'd1);
      queue_string("a&&b||c==d!=e");
      queue_end(8'h00);
      queue_string("!x&|=");
      queue_char(8'hFF);
      queue_string("+-*/( )!");
      queue_end(8'hFF);
      send_text();

      // Random phases. The keyword settings walk through short and full-length keywords,
      // an all-ones pattern that no word can match, disabled and out-of-range lengths,
      // and two identical keywords where the first must win.
      run_phase(IDLE_NONE, 64'h6669, 4'd2, 64'h0000_0065_6C69_6877, 4'd5);
      run_phase(IDLE_SENDER, 64'h6E6F_6974_636E_7566, 4'd8, 64'h74_656C, 4'd3);
      run_phase(IDLE_RECEIVER, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h6F64, 4'd2);
      run_phase(IDLE_BOTH, 64'h0, 4'd0, 64'h72_6F66, 4'd15);
      run_phase(IDLE_BOTH, 64'h6241, 4'd2, 64'h6241, 4'd2);
      run_phase(IDLE_RECEIVER, 64'h78, 4'd1, 64'h7A7A_7A7A_7A7A_7A7A, 4'd8);

      // Let every expected token come out, then watch a little longer for strays.
      wait_idle();
      if (mismatch_count == 0 && tokens_outstanding == 0) begin
         $display("tb_expression_token_lexer: done, clean");
      end else begin
         $display("tb_expression_token_lexer: done, errors");
      end
      $finish;
   end

endmodule
